// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes of the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ple_pkg;
   localparam int ACTION_W = 3;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_READ    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FIND    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REVERSE = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      DP_NONE   = 3'd0,
      DP_LOAD   = 3'd1,  // latch the request, clear the result
      DP_RD_A   = 3'd2,  // read memory at index A
      DP_WR_A   = 3'd3,  // write latched value at A
      DP_WR_B   = 3'd4,  // write held read data at B
      DP_WR_T   = 3'd5,  // write swap temp at B
      DP_CAP    = 3'd6   // capture read data into temp
   } dp_op_type;
endpackage
`default_nettype wire

// ===== rtl/ple_if.sv =====
// ----------------------------------------------------------------------------
// ple_req_if / ple_rsp_if
// Valid/ready channels of the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none
interface ple_req_if;
   import ple_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [POS_W-1:0]    position;
   logic signed [DATA_W-1:0] value;
   modport source (output valid, action, position, value, input ready);
   modport sink   (input valid, action, position, value, output ready);
endinterface

interface ple_rsp_if;
   import ple_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic signed [DATA_W-1:0] data_out;
   logic                found;
   logic [POS_W-1:0]    found_position;
   logic [POS_W-1:0]    count_out;
   modport source (output valid, status, data_out, found, found_position, count_out,
                   input ready);
   modport sink   (input valid, status, data_out, found, found_position, count_out,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/ple_ram.sv =====
// ----------------------------------------------------------------------------
// ple_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/ple_datapath.sv =====
// ----------------------------------------------------------------------------
// ple_datapath
// Element memory, request latch, swap temp and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module ple_datapath import ple_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32,
   parameter int IDX_W      = $clog2(CAPACITY)
) (
   input  wire logic                  clock,
   input  wire dp_op_type             op,
   input  wire logic [IDX_W-1:0]      idx_a,
   input  wire logic [IDX_W-1:0]      idx_b,
   input  wire logic [DATA_W-1:0]     req_value,
   input  wire logic                  set_data,   // result data from read data
   input  wire logic                  set_found,
   input  wire logic [POS_W-1:0]      found_pos,
   input  wire logic [STATUS_W-1:0]   status_in,
   input  wire logic                  set_status,
   output      logic                  match,
   output      logic [STATUS_W-1:0]   status,
   output      logic [DATA_W-1:0]     data_out,
   output      logic                  found,
   output      logic [POS_W-1:0]      found_position
);
   logic [ELEM_WIDTH-1:0] value_ff, temp_ff, rd_data, wr_data;
   logic [IDX_W-1:0]      addr;
   logic                  wr_en;

   always_comb begin
      wr_en   = 1'b0;
      addr    = idx_a;
      wr_data = value_ff;
      case (op)
         DP_WR_A: wr_en = 1'b1;
         DP_WR_B: begin wr_en = 1'b1; addr = idx_b; wr_data = rd_data; end
         DP_WR_T: begin wr_en = 1'b1; addr = idx_b; wr_data = temp_ff; end
         default: ;
      endcase
   end

   ple_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data)
   );

   assign match = (rd_data == value_ff);

   always_ff @(posedge clock) begin
      if (op == DP_LOAD) begin
         value_ff       <= req_value[ELEM_WIDTH-1:0];
         data_out       <= '0;
         found          <= 1'b0;
         found_position <= '0;
         status         <= ST_OK;
      end
      if (op == DP_CAP) begin
         temp_ff <= rd_data;
      end
      if (set_data) begin
         data_out <= DATA_W'($signed(rd_data));
      end
      if (set_found) begin
         found          <= 1'b1;
         found_position <= found_pos;
      end
      if (set_status) begin
         status <= status_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer of the positional list engine: checks, shifts, scans, swaps.
// ----------------------------------------------------------------------------
`default_nettype none
module ple_ctrl import ple_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY+1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [POS_W-1:0]    req_position,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic                match,
   output      dp_op_type           op,
   output      logic [IDX_W-1:0]    idx_a,
   output      logic [IDX_W-1:0]    idx_b,
   output      logic                set_data,
   output      logic                set_found,
   output      logic [POS_W-1:0]    found_pos,
   output      logic [STATUS_W-1:0] status_in,
   output      logic                set_status,
   output      logic [CNT_W-1:0]    count
);
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_DISP = 9'b000000010,
      S_RD   = 9'b000000100,  // read or write at a; read data valid next state
      S_USE  = 9'b000001000,
      S_INS  = 9'b000010000,
      S_REM  = 9'b000100000,
      S_FIND = 9'b001000000,
      S_REV  = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [ACTION_W-1:0] act_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [CNT_W:0]      i_ff, i_in, j_ff, j_in;   // work indices, one bit spare
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [1:0]          ph_ff, ph_in;
   logic                pos_ok, ins_ok;
   logic                tw_ff;
   logic [IDX_W-1:0]    tw_idx_ff;

   assign count = count_ff;
   assign pos_ok = (pos_ff != '0) && ({1'b0, pos_ff} <= (POS_W+1)'(count_ff));
   assign ins_ok = (pos_ff != '0) && ({1'b0, pos_ff} <= (POS_W+1)'(count_ff) + 1'b1);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      state_in = state_ff; i_in = i_ff; j_in = j_ff; count_in = count_ff; ph_in = ph_ff;
      op = DP_NONE; idx_a = i_ff[IDX_W-1:0]; idx_b = j_ff[IDX_W-1:0];
      set_data = 1'b0; set_found = 1'b0; found_pos = POS_W'(i_ff + 1'b1);
      status_in = ST_OK; set_status = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid) begin op = DP_LOAD; state_in = S_DISP; end
         S_DISP: begin
            state_in = S_DONE;
            i_in = (CNT_W+1)'(pos_ff) - 1'b1;
            ph_in = 2'd0;
            case (act_ff)
               ACT_READ, ACT_WRITE: begin
                  if (!pos_ok) begin set_status = 1'b1; status_in = ST_RANGE; end
                  else state_in = S_RD;
               end
               ACT_FIND: begin i_in = '0; state_in = S_FIND; end
               ACT_INSERT: begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     set_status = 1'b1; status_in = ST_FULL;
                  end else if (!ins_ok) begin
                     set_status = 1'b1; status_in = ST_RANGE;
                  end else begin
                     i_in = (CNT_W+1)'(count_ff); state_in = S_INS;
                  end
               end
               ACT_REMOVE: begin
                  if (count_ff == '0) begin set_status = 1'b1; status_in = ST_EMPTY; end
                  else if (!pos_ok) begin set_status = 1'b1; status_in = ST_RANGE; end
                  else state_in = S_RD;
               end
               ACT_REVERSE: begin
                  i_in = '0; j_in = (CNT_W+1)'(count_ff) - 1'b1;
                  if (count_ff > CNT_W'(1)) state_in = S_REV;
               end
               default: ;
            endcase
         end
         S_RD: begin
            if (act_ff == ACT_WRITE) begin
               op = DP_WR_A; state_in = S_DONE;
            end else begin
               op = DP_RD_A; state_in = S_USE;
            end
         end
         S_USE: begin
            set_data = 1'b1;
            if (act_ff == ACT_REMOVE) begin
               j_in = i_ff; i_in = i_ff + 1'b1; state_in = S_REM;
            end else state_in = S_DONE;
         end
         // Shift up: read i-1, then write it at i, walking down to the slot.
         S_INS: begin
            if (i_ff == (CNT_W+1)'(pos_ff) - 1'b1) begin
               op = DP_WR_A; count_in = count_ff + 1'b1; state_in = S_DONE;
            end else if (ph_ff == 2'd0) begin
               op = DP_RD_A; idx_a = IDX_W'(i_ff - 1'b1); ph_in = 2'd1;
            end else begin
               op = DP_WR_B; idx_b = i_ff[IDX_W-1:0]; i_in = i_ff - 1'b1; ph_in = 2'd0;
            end
         end
         // Shift down: read i, write it at i-1.
         S_REM: begin
            if (i_ff >= (CNT_W+1)'(count_ff)) begin
               count_in = count_ff - 1'b1; state_in = S_DONE;
            end else if (ph_ff == 2'd0) begin
               op = DP_RD_A; ph_in = 2'd1;
            end else begin
               op = DP_WR_B; idx_b = IDX_W'(i_ff - 1'b1); i_in = i_ff + 1'b1; ph_in = 2'd0;
            end
         end
         S_FIND: begin
            if (ph_ff == 2'd0) begin
               if (i_ff >= (CNT_W+1)'(count_ff)) state_in = S_DONE;
               else begin op = DP_RD_A; ph_in = 2'd1; end
            end else if (match) begin
               set_found = 1'b1; state_in = S_DONE;
            end else begin
               i_in = i_ff + 1'b1; ph_in = 2'd0;
            end
         end
         // Swap: read lo, keep it, read hi, write hi at lo, temp at hi.
         S_REV: begin
            case (ph_ff)
               2'd0: begin
                  if (i_ff >= j_ff) state_in = S_DONE;
                  else begin op = DP_RD_A; ph_in = 2'd1; end
               end
               2'd1: begin op = DP_CAP; idx_a = j_ff[IDX_W-1:0]; ph_in = 2'd2; end
               2'd2: begin
                  op = DP_RD_A; idx_a = j_ff[IDX_W-1:0]; ph_in = 2'd3;
               end
               default: begin
                  op = DP_WR_B; idx_b = i_ff[IDX_W-1:0];
                  ph_in = 2'd0; i_in = i_ff + 1'b1; j_in = j_ff - 1'b1;
               end
            endcase
            if (ph_ff == 2'd3) begin
               // temp goes to hi after lo is written
               state_in = S_REV;
            end
         end
         S_DONE: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // The pending temp write takes the memory port for one cycle.
      if (tw_ff) begin
         op = DP_WR_T; idx_b = tw_idx_ff;
      end
   end

   // The reverse needs a second write per pair; it is issued from a flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; ph_ff <= '0; tw_ff <= 1'b0;
      end else if (tw_ff) begin
         tw_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ph_ff <= ph_in;
         tw_ff <= (state_ff == S_REV) && (ph_ff == 2'd3);
      end
   end

   // Work indices and the held index of the pending temp write; request latch.
   always_ff @(posedge clock) begin
      if (!tw_ff) begin
         i_ff <= i_in; j_ff <= j_in;
         if (state_ff == S_REV && ph_ff == 2'd3) tw_idx_ff <= j_ff[IDX_W-1:0];
      end
      if (state_ff == S_IDLE && req_valid) begin
         act_ff <= req_action; pos_ff <= req_position;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded positional list with read, write, find, insert, remove, reverse.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | action, position, value
//  rsp     | out | status, data_out, found, found_position, count_out
//
//  Find compares one entry at a time, insert and remove shift one entry at a
//  time with a read and a write each, and reverse swaps pairs with two reads and
//  two writes each, all through the one port of the element RAM. Reset returns
//  the sequencer to idle and clears the count. The result holds in its register
//  until taken; no request is taken until then.
`default_nettype none
module positional_list_engine_unit import ple_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input wire logic clock,
   input wire logic reset,
   ple_req_if.sink   req,
   ple_rsp_if.source rsp
);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY+1);

   dp_op_type op_c, op;
   logic [IDX_W-1:0] ia, ib;
   logic sd, sf, ss, match;
   logic [POS_W-1:0] fp;
   logic [STATUS_W-1:0] si;
   logic [CNT_W-1:0] count;

   ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_action(req.action), .req_position(req.position),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .match(match),
      .op(op_c), .idx_a(ia), .idx_b(ib), .set_data(sd), .set_found(sf),
      .found_pos(fp), .status_in(si), .set_status(ss), .count(count)
   );

   assign op = op_c;

   ple_datapath #(.CAPACITY(CAPACITY), .ELEM_WIDTH(DATA_W)) u_dp (
      .clock(clock), .op(op), .idx_a(ia), .idx_b(ib), .req_value(req.value),
      .set_data(sd), .set_found(sf), .found_pos(fp), .status_in(si),
      .set_status(ss), .match(match), .status(rsp.status), .data_out(rsp.data_out),
      .found(rsp.found), .found_position(rsp.found_position)
   );

   assign rsp.count_out = POS_W'(count);
endmodule
`default_nettype wire

// ===== tb/sv/positional_list_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb
// Self-checking bench for the positional list engine. A directed table and a
// fill to capacity cover the error codes and the edges of the list, then random
// request traffic, in phases that drive the list toward empty or full, is
// checked against a behavioral list model with random idling on both channels.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;
   import ple_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP     = 64;
   localparam int N_RAND  = 1250;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data_out;
      logic                     found;
      logic [POS_W-1:0]         found_position;
      logic [POS_W-1:0]         count_out;
   } list_rsp_t;

   typedef struct {
      logic [ACTION_W-1:0]      action;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
      bit                       typed;
      list_rsp_t                rsp;
   } req_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ple_req_if req ();
   ple_rsp_if rsp ();

   positional_list_engine_unit #(.CAPACITY(CAP)) i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [DATA_W-1:0] list_mem [CAP];
   int                       list_len;
   list_rsp_t                pending_rsp [$];
   int                       errors;
   bit                       no_idle;

   function automatic list_rsp_t mk_rsp(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] d,
                                        logic f, logic [POS_W-1:0] fp, int cnt);
      list_rsp_t r;
      r.status = st; r.data_out = d; r.found = f; r.found_position = fp;
      r.count_out = cnt[POS_W-1:0];
      return r;
   endfunction

   // Applies one request to the list model and returns its result.
   function automatic list_rsp_t list_apply(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                            logic signed [DATA_W-1:0] val);
      int p;
      int lo, hi;
      logic signed [DATA_W-1:0] t;
      p = pos;
      case (act)
         ACT_READ: begin
            if (p < 1 || p > list_len) return mk_rsp(ST_RANGE, 0, 0, 0, list_len);
            return mk_rsp(ST_OK, list_mem[p-1], 0, 0, list_len);
         end
         ACT_WRITE: begin
            if (p < 1 || p > list_len) return mk_rsp(ST_RANGE, 0, 0, 0, list_len);
            list_mem[p-1] = val;
            return mk_rsp(ST_OK, 0, 0, 0, list_len);
         end
         ACT_FIND: begin
            for (int i = 0; i < list_len; i++)
               if (list_mem[i] == val) return mk_rsp(ST_OK, 0, 1, i + 1, list_len);
            return mk_rsp(ST_OK, 0, 0, 0, list_len);
         end
         ACT_INSERT: begin
            if (list_len >= CAP) return mk_rsp(ST_FULL, 0, 0, 0, list_len);
            if (p < 1 || p > list_len + 1) return mk_rsp(ST_RANGE, 0, 0, 0, list_len);
            for (int i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i-1];
            list_mem[p-1] = val;
            list_len++;
            return mk_rsp(ST_OK, 0, 0, 0, list_len);
         end
         ACT_REMOVE: begin
            if (list_len == 0) return mk_rsp(ST_EMPTY, 0, 0, 0, list_len);
            if (p < 1 || p > list_len) return mk_rsp(ST_RANGE, 0, 0, 0, list_len);
            t = list_mem[p-1];
            for (int i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
            return mk_rsp(ST_OK, t, 0, 0, list_len);
         end
         ACT_REVERSE: begin
            lo = 0;
            hi = list_len - 1;
            while (lo < hi) begin
               t = list_mem[lo]; list_mem[lo] = list_mem[hi]; list_mem[hi] = t;
               lo++;
               hi--;
            end
            return mk_rsp(ST_OK, 0, 0, 0, list_len);
         end
         default: return mk_rsp(ST_OK, 0, 0, 0, list_len);
      endcase
   endfunction

   task automatic send_req(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val, bit typed, list_rsp_t want);
      list_rsp_t r;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req.valid    <= 1'b1;
      req.action   <= act;
      req.position <= pos;
      req.value    <= val;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      r = list_apply(act, pos, val);
      if (typed && r != want)
         $display("directed row disagrees with model: act %0d pos %0d", act, pos);
      pending_rsp.push_back(typed ? want : r);
      @(negedge clock);
   endtask

   // Result checker: compares every transfer with the oldest expectation.
   always @(posedge clock) begin
      list_rsp_t exp_r, got;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.status, rsp.data_out, rsp.found, rsp.found_position, rsp.count_out};
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
         end else begin
            exp_r = pending_rsp.pop_front();
            if (got != exp_r) begin
               errors++;
               if (errors <= 10) $display("result mismatch: expected %p, got %p", exp_r, got);
            end
         end
      end
   end

   // Result-side stall bursts.
   initial begin
      int n;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!no_idle && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            rsp.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      #20ms;
      $display("positional_list_engine_unit: mismatch");
      $finish;
   end

   initial begin
      req_row_t rows [$];
      logic [ACTION_W-1:0] act;
      logic [POS_W-1:0] pos;
      logic signed [DATA_W-1:0] val;
      int mode, k;
      list_rsp_t none;
      none = '0;
      errors = 0; no_idle = 0; list_len = 0;
      foreach (list_mem[i]) list_mem[i] = '0;
      req.valid = 1'b0; req.action = '0; req.position = '0; req.value = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table; typed results are the obvious ones.
      rows.push_back('{ACT_READ,    7'd1,  32'sd0, 1, mk_rsp(ST_RANGE, 0, 0, 0, 0)});
      rows.push_back('{ACT_REMOVE,  7'd1,  32'sd0, 1, mk_rsp(ST_EMPTY, 0, 0, 0, 0)});
      rows.push_back('{ACT_FIND,    7'd0,  32'sd5, 1, mk_rsp(ST_OK, 0, 0, 0, 0)});
      rows.push_back('{ACT_REVERSE, 7'd0,  32'sd0, 1, mk_rsp(ST_OK, 0, 0, 0, 0)});
      rows.push_back('{ACT_INSERT,  7'd2,  32'sd1, 1, mk_rsp(ST_RANGE, 0, 0, 0, 0)});
      rows.push_back('{ACT_INSERT,  7'd0,  32'sd1, 1, mk_rsp(ST_RANGE, 0, 0, 0, 0)});
      rows.push_back('{ACT_INSERT,  7'd1,  32'h8000_0000, 1, mk_rsp(ST_OK, 0, 0, 0, 1)});
      rows.push_back('{ACT_REVERSE, 7'd0,  32'sd0, 1, mk_rsp(ST_OK, 0, 0, 0, 1)});
      rows.push_back('{ACT_READ,    7'd1,  32'sd0, 1, mk_rsp(ST_OK, 32'h8000_0000, 0, 0, 1)});
      rows.push_back('{ACT_INSERT,  7'd2,  32'h7fff_ffff, 1, mk_rsp(ST_OK, 0, 0, 0, 2)});
      rows.push_back('{ACT_FIND,    7'd0,  32'h7fff_ffff, 1, mk_rsp(ST_OK, 0, 1, 2, 2)});
      rows.push_back('{ACT_REMOVE,  7'd3,  32'sd0, 1, mk_rsp(ST_RANGE, 0, 0, 0, 2)});
      rows.push_back('{ACT_WRITE,   7'd127, -32'sd1, 1, mk_rsp(ST_RANGE, 0, 0, 0, 2)});
      rows.push_back('{ACT_WRITE,   7'd1,  -32'sd1, 1, mk_rsp(ST_OK, 0, 0, 0, 2)});
      rows.push_back('{ACT_REVERSE, 7'd0,  32'sd0, 0, none});
      rows.push_back('{ACT_READ,    7'd2,  32'sd0, 0, none});
      rows.push_back('{3'd6,        7'd1,  32'sd9, 1, mk_rsp(ST_OK, 0, 0, 0, 2)});
      rows.push_back('{3'd7,        7'd127, -32'sd1, 1, mk_rsp(ST_OK, 0, 0, 0, 2)});
      rows.push_back('{ACT_REMOVE,  7'd1,  32'sd0, 0, none});
      rows.push_back('{ACT_REMOVE,  7'd1,  32'sd0, 1, mk_rsp(ST_OK, -32'sd1, 0, 0, 0)});
      foreach (rows[i])
         send_req(rows[i].action, rows[i].position, rows[i].value, rows[i].typed, rows[i].rsp);

      // Fill to capacity, then hit the full list.
      while (list_len < CAP)
         send_req(ACT_INSERT, $urandom_range(1, list_len + 1), $urandom, 0, none);
      send_req(ACT_INSERT, 7'd1, 32'sd3, 1, mk_rsp(ST_FULL, 0, 0, 0, CAP));
      send_req(ACT_REVERSE, 7'd0, 32'sd0, 0, none);
      send_req(ACT_READ, CAP, 32'sd0, 0, none);
      send_req(ACT_FIND, 7'd0, list_mem[CAP-1], 0, none);

      // Hold off until the block has drained everything.
      req.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);

      mode = 0;
      for (int n = 0; n < N_RAND; n++) begin
         if (n % 150 == 0) mode = $urandom_range(0, 2); // 0 grow, 1 shrink, 2 mixed
         if (n > N_RAND - 150) no_idle = 1;
         k = $urandom_range(0, 99);
         if (k < 5) act = $urandom_range(0, 7);
         else if (k < 35) act = (mode == 1) ? ACT_REMOVE : ACT_INSERT;
         else if (k < 50) act = (mode == 0) ? ACT_INSERT : ACT_REMOVE;
         else if (k < 65) act = ACT_READ;
         else if (k < 78) act = ACT_WRITE;
         else if (k < 93) act = ACT_FIND;
         else act = ACT_REVERSE;
         if ($urandom_range(0, 9) == 0) pos = $urandom;
         else pos = $urandom_range(1, list_len + 1);
         if ((act == ACT_READ || act == ACT_WRITE || act == ACT_REMOVE) &&
             pos > list_len && $urandom_range(0, 1)) pos = (list_len > 0) ? list_len : 0;
         if (act == ACT_FIND && list_len > 0 && $urandom_range(0, 1))
            val = list_mem[$urandom_range(0, list_len - 1)];
         else if ($urandom_range(0, 7) == 0)
            val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         else val = $urandom;
         send_req(act, pos, val, 0, none);
      end
      req.valid <= 1'b0;

      k = 0;
      while (pending_rsp.size() != 0 && k < 100000) begin
         @(negedge clock);
         k++;
      end
      repeat (700) @(negedge clock);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("positional_list_engine_unit: match");
      else
         $display("positional_list_engine_unit: mismatch");
      $finish;
   end
endmodule
